### src/dltc_pkg.sv
// Shared types, constants and calendar helper functions for the local time converter.
package dltc_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int OFS_W   = 6;
    localparam int RULE_W  = 2;
    localparam int H_W     = 7;
    localparam int YY_W    = 7;
    localparam int CENT_W  = 6;

    localparam logic [RULE_W-1:0] RULE_NONE = 2'd0;
    localparam logic [RULE_W-1:0] RULE_EU   = 2'd1;
    localparam logic [RULE_W-1:0] RULE_US   = 2'd2;

    localparam logic REG_ZONE_OFFSET = 1'b0;
    localparam logic REG_DST_RULE    = 1'b1;

    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          PROD_W       = YEAR_W + 13;

    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

    localparam logic [3:0] KEY_MAR = 4'd3;
    localparam logic [3:0] KEY_OCT = 4'd0;
    localparam logic [3:0] KEY_NOV = 4'd3;

    localparam logic [DAY_W-1:0] EU_FIRST     = 5'd25;
    localparam logic [DAY_W-1:0] US_MAR_FIRST = 5'd8;
    localparam logic [DAY_W-1:0] US_NOV_FIRST = 5'd1;

    localparam logic [6:0] HOURS_PER_DAY = 7'd24;

    typedef struct packed {
        logic signed [OFS_W-1:0] zone_offset_hours;
        logic [RULE_W-1:0]       dst_rule;
    } cfg_t;

    typedef struct packed {
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic signed [H_W-1:0] h;
        logic [MIN_W-1:0]    minute;
        logic [RULE_W-1:0]   rule;
    } item_t;

    typedef struct packed {
        item_t      item;
        logic [2:0] year_key;
        logic [2:0] cent_code;
    } key_t;

    function automatic logic [2:0] century_code(input logic [1:0] c);
        logic [2:0] r;
        unique case (c)
            2'd0: r = 3'd6;
            2'd1: r = 3'd4;
            2'd2: r = 3'd2;
            2'd3: r = 3'd0;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mod7(input logic [6:0] x);
        logic [6:0] v;
        v = x;
        if (v >= 7'd112) v = v - 7'd112;
        if (v >= 7'd56)  v = v - 7'd56;
        if (v >= 7'd28)  v = v - 7'd28;
        if (v >= 7'd14)  v = v - 7'd14;
        if (v >= 7'd7)   v = v - 7'd7;
        return v[2:0];
    endfunction

    function automatic logic [DAY_W-1:0] first_sunday(input logic [3:0] base,
                                                      input logic [DAY_W-1:0] first);
        logic [2:0] s;
        logic [2:0] step;
        s    = mod7(7'(base) + 7'(first));
        step = (s == 3'd0) ? 3'd0 : 3'd7 - s;
        return first + DAY_W'(step);
    endfunction

endpackage

### src/dltc_cfg.sv
// Configuration registers behind the APB-style port.
module dltc_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output dltc_pkg::cfg_t       cfg
);
    import dltc_pkg::*;

    logic signed [OFS_W-1:0] zone_offset_reg;
    logic [RULE_W-1:0]       dst_rule_reg;
    logic                    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_reg <= '0;
            dst_rule_reg    <= RULE_NONE;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_ZONE_OFFSET: zone_offset_reg <= $signed(pwdata[OFS_W-1:0]);
                REG_DST_RULE:    dst_rule_reg    <= pwdata[RULE_W-1:0];
                default:         dst_rule_reg    <= dst_rule_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ZONE_OFFSET: prdata = 32'(signed'(zone_offset_reg));
            REG_DST_RULE:    prdata = 32'(dst_rule_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.zone_offset_hours = zone_offset_reg;
    assign cfg.dst_rule          = dst_rule_reg;

endmodule

### src/dltc_year_key.sv
// Pipeline stages one to three: split the year into century and year of century, form keys.
module dltc_year_key (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [dltc_pkg::YEAR_W-1:0]       year,
    input  logic [dltc_pkg::MONTH_W-1:0]      month,
    input  logic [dltc_pkg::DAY_W-1:0]        day_of_month,
    input  logic [dltc_pkg::HOUR_W-1:0]       hour,
    input  logic [dltc_pkg::MIN_W-1:0]        minute,
    input  dltc_pkg::cfg_t                    cfg,
    output logic                              key_valid,
    output dltc_pkg::key_t                    key
);
    import dltc_pkg::*;

    logic                  s1_valid_reg;
    item_t                 s1_item_reg;
    logic [YEAR_W-1:0]     s1_year_reg;
    logic [PROD_W-1:0]     s1_prod_reg;

    logic                  s2_valid_reg;
    item_t                 s2_item_reg;
    logic [YY_W-1:0]       s2_yy_reg;
    logic [2:0]            s2_cc_reg;

    logic                  s3_valid_reg;
    item_t                 s3_item_reg;
    logic [2:0]            s3_ym_reg;
    logic [2:0]            s3_cc_reg;

    item_t                 item_in;
    logic [CENT_W-1:0]     cent;
    logic [YEAR_W-1:0]     yy_full;

    always_comb
    begin
        item_in.month  = month;
        item_in.day    = day_of_month;
        item_in.h      = $signed({2'b00, hour})
                       + $signed({cfg.zone_offset_hours[OFS_W-1], cfg.zone_offset_hours});
        item_in.minute = minute;
        item_in.rule   = cfg.dst_rule;
    end

    assign cent    = s1_prod_reg[DIV100_SHIFT +: CENT_W];
    assign yy_full = s1_year_reg - YEAR_W'(cent) * YEAR_W'(100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= item_in;
            s1_year_reg <= year;
            s1_prod_reg <= PROD_W'(year) * PROD_W'(DIV100_MUL);

            s2_item_reg <= s1_item_reg;
            s2_yy_reg   <= yy_full[YY_W-1:0];
            s2_cc_reg   <= century_code(cent[1:0]);

            s3_item_reg <= s2_item_reg;
            s3_ym_reg   <= mod7(YY_W'(s2_yy_reg[YY_W-1:2]) + s2_yy_reg);
            s3_cc_reg   <= s2_cc_reg;
        end
    end

    assign key_valid     = s3_valid_reg;
    assign key.item      = s3_item_reg;
    assign key.year_key  = s3_ym_reg;
    assign key.cent_code = s3_cc_reg;

    a_yy_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_yy_reg < 7'd100))
        else $error("year of century out of range");

endmodule

### src/dltc_dst_eval.sv
// Pipeline stages four and five: find the switch Sundays, decide daylight saving, wrap the hour.
module dltc_dst_eval (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              key_valid,
    input  dltc_pkg::key_t                    key,
    output logic                              out_valid,
    output logic [dltc_pkg::HOUR_W-1:0]       local_hour,
    output logic [dltc_pkg::MIN_W-1:0]        local_minute,
    output logic                              dst_active
);
    import dltc_pkg::*;

    logic              s4_valid_reg;
    item_t             s4_item_reg;
    logic [DAY_W-1:0]  s4_eu_mar_reg;
    logic [DAY_W-1:0]  s4_eu_oct_reg;
    logic [DAY_W-1:0]  s4_us_mar_reg;
    logic [DAY_W-1:0]  s4_us_nov_reg;

    logic              s5_valid_reg;
    logic [HOUR_W-1:0] s5_hour_reg;
    logic [MIN_W-1:0]  s5_minute_reg;
    logic              s5_dst_reg;

    logic [3:0]        base;
    logic              eu_on;
    logic              us_on;
    logic              dst;
    logic              h_ge1;
    logic              h_ge2;
    logic [6:0]        wrap;

    assign base = 4'(key.year_key) + 4'(key.cent_code);

    always_comb
    begin
        h_ge1 = s4_item_reg.h >= 7'sd1;
        h_ge2 = s4_item_reg.h >= 7'sd2;

        eu_on = 1'b0;
        if (s4_item_reg.month >= MONTH_APR && s4_item_reg.month <= MONTH_SEP)
            eu_on = 1'b1;
        else if (s4_item_reg.month == MONTH_MAR)
            eu_on = (s4_item_reg.day == s4_eu_mar_reg) ? h_ge1
                                                       : (s4_item_reg.day > s4_eu_mar_reg);
        else if (s4_item_reg.month == MONTH_OCT)
            eu_on = (s4_item_reg.day == s4_eu_oct_reg) ? !h_ge1
                                                       : (s4_item_reg.day < s4_eu_oct_reg);

        us_on = 1'b0;
        if (s4_item_reg.month >= MONTH_APR && s4_item_reg.month <= MONTH_OCT)
            us_on = 1'b1;
        else if (s4_item_reg.month == MONTH_MAR)
            us_on = (s4_item_reg.day == s4_us_mar_reg) ? h_ge2
                                                       : (s4_item_reg.day > s4_us_mar_reg);
        else if (s4_item_reg.month == MONTH_NOV)
            us_on = (s4_item_reg.day == s4_us_nov_reg) ? !h_ge1
                                                       : (s4_item_reg.day < s4_us_nov_reg);

        priority case (s4_item_reg.rule)
            RULE_EU: dst = eu_on;
            RULE_US: dst = us_on;
            default: dst = 1'b0;
        endcase

        // The biased sum is always positive, so the wrap needs only subtractions.
        wrap = 7'(s4_item_reg.h) + 7'd48 + 7'(dst);
        if (wrap >= 7'd96)          wrap = wrap - 7'd96;
        if (wrap >= 7'd48)          wrap = wrap - 7'd48;
        if (wrap >= HOURS_PER_DAY)  wrap = wrap - HOURS_PER_DAY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= key_valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_item_reg   <= key.item;
            s4_eu_mar_reg <= first_sunday(base + KEY_MAR, EU_FIRST);
            s4_eu_oct_reg <= first_sunday(base + KEY_OCT, EU_FIRST);
            s4_us_mar_reg <= first_sunday(base + KEY_MAR, US_MAR_FIRST);
            s4_us_nov_reg <= first_sunday(base + KEY_NOV, US_NOV_FIRST);

            s5_hour_reg   <= wrap[HOUR_W-1:0];
            s5_minute_reg <= s4_item_reg.minute;
            s5_dst_reg    <= dst;
        end
    end

    assign out_valid    = s5_valid_reg;
    assign local_hour   = s5_hour_reg;
    assign local_minute = s5_minute_reg;
    assign dst_active   = s5_dst_reg;

    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (s5_hour_reg < 5'd24))
        else $error("local hour out of range");

    a_no_rule_no_dst: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s4_valid_reg && s4_item_reg.rule == RULE_NONE) |=> !s5_dst_reg)
        else $error("daylight saving applied without a rule");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && !en) |=> (s5_valid_reg && $stable(s5_hour_reg)
                                   && $stable(s5_dst_reg)))
        else $error("result changed while stalled");

endmodule

### src/dst_local_time_converter_top.sv
// Top level of the local time converter with daylight-saving rules.
//
// Requests enter on the in_valid / in_ready channel carrying a reference date and
// time; each request yields exactly one result on the out_valid / out_ready channel
// with the local hour, the unchanged minute and a daylight-saving flag.
// The zone offset and the rule are set through the APB-style port; write them only
// while no request is in flight.
// The datapath is a five-stage pipeline: the year is split into century and year of
// century by a reciprocal multiply, the year key is reduced modulo 7, the switch
// Sundays are found, and the final stage decides daylight saving and wraps the hour.
// A request passes through the registered stages s1 to s5 before out_valid rises;
// one request is accepted every cycle while the output side keeps up.
// When the receiver holds out_ready low with a result waiting, the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets both registers to zero, which means no offset
// and no daylight saving.
module dst_local_time_converter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dltc_pkg::YEAR_W-1:0]       year,
    input  logic [dltc_pkg::MONTH_W-1:0]      month,
    input  logic [dltc_pkg::DAY_W-1:0]        day_of_month,
    input  logic [dltc_pkg::HOUR_W-1:0]       hour,
    input  logic [dltc_pkg::MIN_W-1:0]        minute,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dltc_pkg::HOUR_W-1:0]       local_hour,
    output logic [dltc_pkg::MIN_W-1:0]        local_minute,
    output logic                              dst_active
);
    import dltc_pkg::*;

    cfg_t  cfg;
    key_t  key;
    logic  key_valid;
    logic  en;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    dltc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dltc_year_key u_year_key (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .cfg          (cfg),
        .key_valid    (key_valid),
        .key          (key)
    );

    dltc_dst_eval u_dst_eval (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .key_valid    (key_valid),
        .key          (key),
        .out_valid    (out_valid),
        .local_hour   (local_hour),
        .local_minute (local_minute),
        .dst_active   (dst_active)
    );

endmodule
